// ----- rtl/core/ms2_pkg.sv -----
// Shared constants, types and helpers for the track-2 stripe reader core.
package ms2_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CHAR_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int POS_W       = 6;
    localparam int EXT_W       = POS_W + IDX_W;
    localparam int BCNT_W      = 3;

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(STORE_DEPTH - 1);
    localparam logic [CHAR_W-1:0] START_SENT  = 5'b01011;
    localparam logic [CHAR_W-1:0] END_SENT    = 5'b11111;
    localparam logic [POS_W-1:0]  MAX_DIGITS  = 6'd40;
    localparam logic [POS_W-1:0]  ID_LEN_RST  = 6'd8;

    localparam logic OP_CLOCK  = 1'b0;
    localparam logic OP_ENABLE = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic              go;
        logic [CHAR_W-1:0] want;
        logic              slot_bad;
        logic [POS_W-1:0]  count;
    } ms2_chk_t;

    // Set bit 4 so the five bits carry odd parity.
    function automatic logic [CHAR_W-1:0] with_odd_parity(input logic [CHAR_W-1:0] v);
        return {~(^v[DIGIT_W-1:0]), v[DIGIT_W-1:0]};
    endfunction

endpackage

// ----- rtl/core/ms2_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ms2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/ms2_framer.sv -----
// Bit-serial character framer: LSB-first window, start sentinel hunt, 5-bit framing.
module ms2_framer
    import ms2_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              shift,
    input  logic              bit_in,
    output logic              char_stb,
    output logic              char_start,
    output logic [CHAR_W-1:0] char_data
);

    logic [CHAR_W-1:0] win_reg, win_next;
    logic [BCNT_W-1:0] cnt_reg, cnt_next;
    logic              hunt_reg, hunt_next;
    logic [CHAR_W-1:0] win_fill;

    always_comb
    begin
        for (int i = 0; i < CHAR_W; i++)
        begin
            win_fill[i] = win_reg[i] | (bit_in & (cnt_reg == BCNT_W'(i)));
        end
    end

    always_comb
    begin
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        hunt_next  = hunt_reg;
        char_stb   = 1'b0;
        char_start = 1'b0;
        char_data  = win_fill;
        if (clear)
        begin
            win_next  = '0;
            cnt_next  = '0;
            hunt_next = 1'b1;
        end
        else if (shift)
        begin
            if (cnt_reg != BCNT_W'(CHAR_W - 1))
            begin
                win_next = win_fill;
                cnt_next = cnt_reg + 1'b1;
            end
            else if (hunt_reg && (win_fill != START_SENT))
            begin
                // slide the window one bit and keep hunting
                win_next = win_fill >> 1;
                cnt_next = BCNT_W'(CHAR_W - 1);
            end
            else
            begin
                char_stb   = 1'b1;
                char_start = hunt_reg;
                win_next   = '0;
                cnt_next   = '0;
                hunt_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            cnt_reg  <= '0;
            hunt_reg <= 1'b1;
        end
        else
        begin
            win_reg  <= win_next;
            cnt_reg  <= cnt_next;
            hunt_reg <= hunt_next;
        end
    end

endmodule

// ----- rtl/core/ms2_readout.sv -----
// LRC check and digit readout sequencer with output register.
module ms2_readout
    import ms2_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ms2_chk_t           chk,
    input  logic [CHAR_W-1:0]  rd_data,
    input  logic               rd_hit,
    output logic               busy,
    output logic [POS_W-1:0]   rd_pos,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIGIT_W-1:0] digit,
    output logic               status,
    output logic               last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHK  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CHAR_W-1:0]  want_reg, want_next;
    logic               bad_reg, bad_next;
    logic [POS_W-1:0]   cnt_reg, cnt_next;
    logic               ovld_reg, ovld_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               status_reg, status_next;
    logic               last_reg, last_next;

    logic               load_ok;
    logic [CHAR_W-1:0]  stored;
    logic [EXT_W-1:0]   pos_ext;
    logic               pos_in_store;

    assign load_ok      = !ovld_reg || out_ready;
    assign stored       = rd_hit ? rd_data : '0;
    assign pos_ext      = {{IDX_W{1'b0}}, pos_reg};
    assign pos_in_store = pos_ext < EXT_W'(STORE_DEPTH);

    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        want_next   = want_reg;
        bad_next    = bad_reg;
        cnt_next    = cnt_reg;
        ovld_next   = ovld_reg && !out_ready;
        digit_next  = digit_reg;
        status_next = status_reg;
        last_next   = last_reg;
        rd_pos      = pos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (chk.go)
                begin
                    want_next  = chk.want;
                    bad_next   = chk.slot_bad;
                    cnt_next   = chk.count;
                    state_next = ST_CHK;
                end
            end
            ST_CHK:
            begin
                rd_pos   = POS_W'(1);
                pos_next = POS_W'(1);
                if (bad_reg || (stored != want_reg))
                begin
                    state_next = ST_ERR;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    ovld_next   = 1'b1;
                    digit_next  = (pos_in_store && rd_hit) ? rd_data[DIGIT_W-1:0] : '0;
                    status_next = STATUS_OK;
                    last_next   = (pos_reg == cnt_reg);
                    rd_pos      = pos_reg + 1'b1;
                    pos_next    = pos_reg + 1'b1;
                    if (pos_reg == cnt_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (load_ok)
                begin
                    ovld_next   = 1'b1;
                    digit_next  = '0;
                    status_next = STATUS_ERR;
                    last_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        want_reg   <= want_next;
        bad_reg    <= bad_next;
        cnt_reg    <= cnt_next;
        digit_reg  <= digit_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = ovld_reg;
    assign digit     = digit_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ----- rtl/core/magstripe_track2_reader_core.sv -----
// Top level of the ABA track-2 magnetic stripe reader core.
// Input transactions are card-reader events: op selects a falling edge of the card
// clock (data_level carries the active-low data bit) or a change of the active-low
// enable line (enable_level). While a card is present the framer slides a 5-bit
// LSB-first window, one bit per clock event, until the start sentinel appears,
// then frames 5-bit characters into a 64-entry store. On removal after an end
// sentinel the readout checks the LRC (the store read at the removal edge, then a
// compare state) and then streams min(id_length, 40) digits with the parity bit
// cleared, one per cycle through the store's registered read port while the output
// register can take them, or a single error transaction on mismatch or when the
// end sentinel sits in the last store slot. in_ready stays low from the cycle after
// the removal until the last transaction is loaded into the output register (for a
// good read with no digits, until the compare ends), also while out_ready holds the
// output register full. The last transaction may still wait in the output register
// after in_ready returns high.
// Entries never written since reset read as zero through per-entry valid flags, so
// no clearing pass follows reset. id_length resets to 8 and is written through the
// cfg channel, which is always ready; write it only while the core is quiet.
module magstripe_track2_reader_core
    import ms2_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // event channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic               data_level,
    input  logic               enable_level,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIGIT_W-1:0] digit,
    output logic               status,
    output logic               last,
    // configuration channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [POS_W-1:0]   cfg_id_length
);

    logic               card_reg, card_next;
    logic [IDX_W-1:0]   ccnt_reg, ccnt_next;
    logic               end_seen_reg, end_seen_next;
    logic [IDX_W-1:0]   end_idx_reg, end_idx_next;
    logic [CHAR_W-1:0]  lrc_reg, lrc_next;
    logic [POS_W-1:0]   id_len_reg;
    logic [STORE_DEPTH-1:0] vld_reg;
    logic               hit_reg;

    logic               in_acc;
    logic               clk_evt;
    logic               card_in;
    logic               card_out;
    logic               char_stb;
    logic               char_start;
    logic [CHAR_W-1:0]  char_data;
    logic               busy;
    logic [POS_W-1:0]   rd_pos;
    logic [EXT_W-1:0]   rd_pos_ext;
    logic [IDX_W-1:0]   rd_addr;
    logic [CHAR_W-1:0]  rd_data;
    ms2_chk_t           chk;

    // Decode the accepted event.
    assign in_ready = !busy;
    assign in_acc   = in_valid && in_ready;
    assign clk_evt  = in_acc && (op == OP_CLOCK) && card_reg;
    assign card_in  = in_acc && (op == OP_ENABLE) && !enable_level;
    assign card_out = in_acc && (op == OP_ENABLE) && enable_level;

    assign cfg_ready = 1'b1;

    ms2_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (card_in || card_out),
        .shift      (clk_evt),
        .bit_in     (~data_level),
        .char_stb   (char_stb),
        .char_start (char_start),
        .char_data  (char_data)
    );

    // Track the character index, the first end sentinel and the running LRC.
    always_comb
    begin
        card_next     = card_reg;
        ccnt_next     = ccnt_reg;
        end_seen_next = end_seen_reg;
        end_idx_next  = end_idx_reg;
        lrc_next      = lrc_reg;
        if (card_in || card_out)
        begin
            card_next     = card_in;
            ccnt_next     = '0;
            end_seen_next = 1'b0;
            end_idx_next  = '0;
            lrc_next      = '0;
        end
        else if (char_stb)
        begin
            if (char_start)
            begin
                lrc_next  = lrc_reg ^ char_data;
                ccnt_next = IDX_W'(1);
            end
            else
            begin
                if (!end_seen_reg)
                begin
                    lrc_next = lrc_reg ^ char_data;
                    if (char_data == END_SENT)
                    begin
                        end_seen_next = 1'b1;
                        end_idx_next  = ccnt_reg;
                    end
                end
                // saturate on the last slot; later characters overwrite it
                if (ccnt_reg != LAST_IDX)
                begin
                    ccnt_next = ccnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_reg     <= 1'b0;
            ccnt_reg     <= '0;
            end_seen_reg <= 1'b0;
            end_idx_reg  <= '0;
            lrc_reg      <= '0;
            id_len_reg   <= ID_LEN_RST;
            vld_reg      <= '0;
        end
        else
        begin
            card_reg     <= card_next;
            ccnt_reg     <= ccnt_next;
            end_seen_reg <= end_seen_next;
            end_idx_reg  <= end_idx_next;
            lrc_reg      <= lrc_next;
            if (cfg_valid && cfg_ready)
            begin
                id_len_reg <= cfg_id_length;
            end
            if (char_stb)
            begin
                vld_reg[ccnt_reg] <= 1'b1;
            end
        end
    end

    // Read the slot after the end sentinel while idle; the readout drives
    // the address once it runs.
    assign rd_pos_ext = {{IDX_W{1'b0}}, rd_pos};
    assign rd_addr    = busy ? rd_pos_ext[IDX_W-1:0] : (end_idx_reg + 1'b1);

    ms2_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (char_stb),
        .wr_addr (ccnt_reg),
        .wr_data (char_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Hold the valid flag of the entry read, aligned with the RAM read data.
    always_ff @(posedge clk)
    begin
        hit_reg <= vld_reg[rd_addr];
    end

    // Launch the check on a removal that follows an end sentinel.
    assign chk.go       = card_out && end_seen_reg;
    assign chk.want     = with_odd_parity(lrc_reg);
    assign chk.slot_bad = (end_idx_reg == LAST_IDX);
    assign chk.count    = (id_len_reg > MAX_DIGITS) ? MAX_DIGITS : id_len_reg;

    ms2_readout u_readout (
        .clk       (clk),
        .rst_n     (rst_n),
        .chk       (chk),
        .rd_data   (rd_data),
        .rd_hit    (hit_reg),
        .busy      (busy),
        .rd_pos    (rd_pos),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .digit     (digit),
        .status    (status),
        .last      (last)
    );

endmodule
